### hw/rtl/memory_test_pattern_checker_defines.svh
// Assertion macros shared by the memory test pattern checker RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MEMORY_TEST_PATTERN_CHECKER_DEFINES_SVH
`define MEMORY_TEST_PATTERN_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define MTPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds across reset.
`define MTPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/mtpc_pkg.sv
// Package of the memory test pattern checker: codes, mixing constants and
// pattern helper functions. No dependencies.
package mtpc_pkg;

  // Default sizes handed down from the top level.
  localparam int ADDR_BITS_DEF   = 32;
  localparam int REQ_BITS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port geometry: three registers on 8-byte spacing.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // Mixing constants of the pseudo-random pattern.
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2     = 64'h94D049BB133111EB;
  localparam logic [63:0] ADDR_MUL     = 64'hD1B54A32D192ED03;

  // Fixed data patterns.
  localparam logic [63:0] WORD_AA   = 64'hAAAAAAAAAAAAAAAA;
  localparam logic [63:0] WORD_55   = 64'h5555555555555555;
  localparam logic [63:0] WORD_ONES = 64'hFFFFFFFFFFFFFFFF;

  // Item actions. The spare code is handled as a fill.
  typedef enum logic [1:0] {
    ACT_FILL   = 2'd0,
    ACT_VERIFY = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_UNUSED = 2'd3
  } act_t;

  // Pattern select codes. The spare code gives a zero word.
  typedef enum logic [2:0] {
    PAT_ZEROS        = 3'd0,
    PAT_ALL_ONES     = 3'd1,
    PAT_AA           = 3'd2,
    PAT_55           = 3'd3,
    PAT_WALKING_ONE  = 3'd4,
    PAT_WALKING_ZERO = 3'd5,
    PAT_RANDOM       = 3'd6,
    PAT_UNUSED       = 3'd7
  } pat_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_SEED    = 2'd1,
    REG_ROUND   = 2'd2
  } reg_idx_t;

  // Front end states.
  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_CALC = 2'd1,
    FR_PUSH = 2'd2
  } front_st_t;

  // The four 64-bit products of the pseudo-random word, in order.
  typedef enum logic [1:0] {
    MIX_ADDR  = 2'd0,
    MIX_ROUND = 2'd1,
    MIX_M1    = 2'd2,
    MIX_FINAL = 2'd3
  } mix_op_t;

  // Steps of one 64-bit product on the shared 32x32 multiplier.
  typedef enum logic [2:0] {
    SUB_LL   = 3'd0,
    SUB_LH   = 3'd1,
    SUB_HL   = 3'd2,
    SUB_ADD  = 3'd3,
    SUB_POST = 3'd4
  } mix_sub_t;

  // Live configuration seen by the pattern generator.
  typedef struct packed {
    logic [2:0]  pat_sel;
    logic [63:0] seed;
    logic [31:0] pass_round;
  } cfg_t;

  // Unused action code is handled as a fill.
  function automatic act_t classify_action(logic [1:0] code);
    act_t act;
    case (code)
      ACT_VERIFY: act = ACT_VERIFY;
      ACT_CLEAR:  act = ACT_CLEAR;
      default:    act = ACT_FILL;
    endcase
    return act;
  endfunction

  // Constant multiplier used by each product of the mixing sequence.
  function automatic logic [63:0] mix_const(mix_op_t op);
    logic [63:0] k;
    case (op)
      MIX_ADDR:  k = ADDR_MUL;
      MIX_ROUND: k = GOLDEN_GAMMA;
      MIX_M1:    k = MIX_MUL1;
      MIX_FINAL: k = MIX_MUL2;
      default:   k = ADDR_MUL;
    endcase
    return k;
  endfunction

  // Word of every pattern but the pseudo-random one, which reads as zero here.
  function automatic logic [63:0] simple_word(logic [2:0] sel, logic [5:0] sh);
    logic [63:0] one;
    logic [63:0] w;
    one = 64'd1 << sh;
    case (sel)
      PAT_ALL_ONES:     w = WORD_ONES;
      PAT_AA:           w = WORD_AA;
      PAT_55:           w = WORD_55;
      PAT_WALKING_ONE:  w = one;
      PAT_WALKING_ZERO: w = ~one;
      default:          w = '0;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/mtpc_front.sv
// Front end of the memory test pattern checker: accepts items, classifies
// the action and forms the expected word. Depends on mtpc_pkg.
`include "memory_test_pattern_checker_defines.svh"

module mtpc_front #(
  parameter int ADDR_BITS = mtpc_pkg::ADDR_BITS_DEF,
  parameter int REQ_BITS  = mtpc_pkg::REQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mtpc_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [ADDR_BITS-1:0]  in_word_address,
  input  logic [63:0]           in_read_data,
  input  logic [REQ_BITS-1:0]   in_requester_id,
  output logic                  q_valid,
  input  logic                  q_ready,
  output mtpc_pkg::act_t        q_act,
  output logic [ADDR_BITS-1:0]  q_addr,
  output logic [63:0]           q_rd,
  output logic [REQ_BITS-1:0]   q_req,
  output logic [63:0]           q_word
);
  import mtpc_pkg::*;

  // Bits of the address that select the walking bit.
  localparam int SH_W = (ADDR_BITS < 6) ? ADDR_BITS : 6;

  front_st_t              st_r, st_nxt;
  mix_op_t                op_r;
  mix_sub_t               sub_r;
  act_t                   act_r;
  logic [ADDR_BITS-1:0]   addr_r;
  logic [63:0]            rd_r;
  logic [REQ_BITS-1:0]    req_r;
  logic [63:0]            a_r;
  logic [63:0]            v_r;
  logic [63:0]            acc_r;
  logic [63:0]            prod_r;
  logic [63:0]            word_r;

  logic                   accept;
  logic                   is_random;
  logic [5:0]             sh_in;
  logic [63:0]            k;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            mul_p;
  logic [63:0]            mix_v;
  logic [31:0]            round1;

  assign accept    = in_valid && in_ready;
  assign is_random = (cfg.pat_sel == PAT_RANDOM);
  assign sh_in     = 6'(in_word_address[SH_W-1:0]);
  assign round1    = 32'(cfg.pass_round + 32'd1);

  // Handshakes: a new item may enter while the finished one is pushed.
  assign in_ready = (st_r == FR_IDLE) || ((st_r == FR_PUSH) && q_ready);
  assign q_valid  = (st_r == FR_PUSH);
  assign q_act    = act_r;
  assign q_addr   = addr_r;
  assign q_rd     = rd_r;
  assign q_req    = req_r;
  assign q_word   = word_r;

  // Operand selection for the shared multiplier.
  assign k     = mix_const(op_r);
  assign mul_a = (sub_r == SUB_HL) ? a_r[63:32] : a_r[31:0];
  assign mul_b = (sub_r == SUB_LH) ? k[63:32] : k[31:0];
  assign mul_p = mul_a * mul_b;

  // Seed and address product combined with the round product, then offset.
  assign mix_v = (v_r ^ acc_r) + GOLDEN_GAMMA;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FR_IDLE: begin
        if (in_valid) begin
          st_nxt = is_random ? FR_CALC : FR_PUSH;
        end
      end
      FR_CALC: begin
        if ((op_r == MIX_FINAL) && (sub_r == SUB_POST)) begin
          st_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (q_ready) begin
          if (in_valid) begin
            st_nxt = is_random ? FR_CALC : FR_PUSH;
          end else begin
            st_nxt = FR_IDLE;
          end
        end
      end
      default: st_nxt = FR_IDLE;
    endcase
  end

  // Sequencer position through the mixing products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r  <= MIX_ADDR;
      sub_r <= SUB_LL;
    end else if (accept) begin
      op_r  <= MIX_ADDR;
      sub_r <= SUB_LL;
    end else if (st_r == FR_CALC) begin
      if (sub_r == SUB_POST) begin
        sub_r <= SUB_LL;
        op_r  <= mix_op_t'(op_r + 2'd1);
      end else begin
        sub_r <= mix_sub_t'(sub_r + 3'd1);
      end
    end
  end

  // Item capture, product accumulation and mixing steps.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= classify_action(in_action);
      addr_r <= in_word_address;
      rd_r   <= in_read_data;
      req_r  <= in_requester_id;
      if (is_random) begin
        a_r <= 64'(in_word_address) + 64'd1;
      end else begin
        word_r <= simple_word(cfg.pat_sel, sh_in);
      end
    end else if (st_r == FR_CALC) begin
      prod_r <= mul_p;
      case (sub_r)
        SUB_LH: acc_r <= prod_r;
        SUB_HL, SUB_ADD: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
        SUB_POST: begin
          case (op_r)
            MIX_ADDR: begin
              v_r <= cfg.seed ^ acc_r;
              a_r <= 64'(round1);
            end
            MIX_ROUND: a_r <= mix_v ^ (mix_v >> 30);
            MIX_M1:    a_r <= acc_r ^ (acc_r >> 27);
            MIX_FINAL: word_r <= acc_r ^ (acc_r >> 31);
            default:   a_r <= a_r;
          endcase
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  `MTPC_ASSERT(a_front_calc_done, clk, rst_n,
    (st_r == FR_CALC && op_r == MIX_FINAL && sub_r == SUB_POST) |=> (st_r == FR_PUSH),
    "pattern sequencer did not hand its word to the queue")
  `MTPC_ASSERT(a_front_push_hold, clk, rst_n,
    (q_valid && !q_ready) |=> (q_valid && $stable(word_r) && $stable(addr_r)),
    "front item changed while waiting for the queue")

endmodule

### hw/rtl/mtpc_fifo.sv
// Short queue between the front and back parts of the pattern checker.
// Holds packed items; depends on mtpc_pkg and the defines header.
`include "memory_test_pattern_checker_defines.svh"

module mtpc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = mtpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `MTPC_ASSERT(a_fifo_bound, clk, rst_n,
    (count_r == CNT_FULL && !pop) |=> (count_r == CNT_FULL),
    "queue lost an item while full")

endmodule

### hw/rtl/mtpc_back.sv
// Back part of the pattern checker: compares read data, keeps the first
// failure record and holds the result item. Depends on mtpc_pkg.
`include "memory_test_pattern_checker_defines.svh"

module mtpc_back #(
  parameter int ADDR_BITS = mtpc_pkg::ADDR_BITS_DEF,
  parameter int REQ_BITS  = mtpc_pkg::REQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  mtpc_pkg::act_t        q_act,
  input  logic [ADDR_BITS-1:0]  q_addr,
  input  logic [63:0]           q_rd,
  input  logic [REQ_BITS-1:0]   q_req,
  input  logic [63:0]           q_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_expected_word,
  output logic                  out_mismatch,
  output logic                  out_failure_seen,
  output logic [ADDR_BITS-1:0]  out_first_fail_address,
  output logic [63:0]           out_first_fail_expected,
  output logic [63:0]           out_first_fail_actual,
  output logic [REQ_BITS-1:0]   out_first_fail_requester
);
  import mtpc_pkg::*;

  logic                  out_valid_r;
  logic [63:0]           out_word_r;
  logic                  out_mismatch_r;
  logic                  fail_latched_r;
  logic [ADDR_BITS-1:0]  fail_address_r;
  logic [63:0]           fail_expected_r;
  logic [63:0]           fail_actual_r;
  logic [REQ_BITS-1:0]   fail_requester_r;
  logic                  pop;
  logic                  miss;

  // The output register frees up when empty or being taken.
  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;
  assign miss    = (q_act == ACT_VERIFY) && (q_rd != q_word);

  // The record only moves when a new result is loaded, so it is shown directly.
  assign out_valid                = out_valid_r;
  assign out_expected_word        = out_word_r;
  assign out_mismatch             = out_mismatch_r;
  assign out_failure_seen         = fail_latched_r;
  assign out_first_fail_address   = fail_address_r;
  assign out_first_fail_expected  = fail_expected_r;
  assign out_first_fail_actual    = fail_actual_r;
  assign out_first_fail_requester = fail_requester_r;

  // Sticky first failure record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_latched_r   <= 1'b0;
      fail_address_r   <= '0;
      fail_expected_r  <= '0;
      fail_actual_r    <= '0;
      fail_requester_r <= '0;
    end else if (pop) begin
      case (q_act)
        ACT_VERIFY: begin
          if (miss && !fail_latched_r) begin
            fail_latched_r   <= 1'b1;
            fail_address_r   <= q_addr;
            fail_expected_r  <= q_word;
            fail_actual_r    <= q_rd;
            fail_requester_r <= q_req;
          end
        end
        ACT_CLEAR: begin
          fail_latched_r   <= 1'b0;
          fail_address_r   <= '0;
          fail_expected_r  <= '0;
          fail_actual_r    <= '0;
          fail_requester_r <= '0;
        end
        default: fail_latched_r <= fail_latched_r;
      endcase
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r     <= q_word;
      out_mismatch_r <= miss;
    end
  end

  `MTPC_ASSERT(a_back_sticky, clk, rst_n,
    (pop && q_act != ACT_CLEAR && fail_latched_r) |=>
      (fail_latched_r && $stable(fail_address_r) && $stable(fail_actual_r)),
    "first failure record was overwritten")
  `MTPC_ASSERT(a_back_no_miss, clk, rst_n,
    (pop && q_act != ACT_VERIFY) |=> !out_mismatch_r,
    "mismatch flagged on an item that does not verify")
  `MTPC_ASSERT_ALWAYS(a_back_reset, clk,
    !rst_n |=> (!out_valid_r && !fail_latched_r),
    "reset left a result or a failure record behind")

endmodule

### hw/rtl/memory_test_pattern_checker.sv
// Memory test pattern checker: every item names a word address and gets one result
// item with the expected test word; a verify item also compares the read data and
// keeps the first failure. With the fixed patterns (zeros, ones, AA, 55, walking
// one, walking zero) the block takes one item per cycle unless the results stall.
// With the pseudo-random pattern each item goes through the single 32x32
// multiplier that its four 64-bit products share, five steps each; the front end
// takes the next item as it hands the word on. The front end's item register, the
// queue and the output register lie between the accepting edge and out_valid. A
// two-entry queue and an output register let the input and result sides stall
// independently. Registers sit at byte addresses 0 (pattern select), 8 (seed) and
// 16 (pass round). Depends on mtpc_pkg, mtpc_front, mtpc_fifo and mtpc_back.
module memory_test_pattern_checker #(
  parameter int ADDR_BITS   = mtpc_pkg::ADDR_BITS_DEF,
  parameter int REQ_BITS    = mtpc_pkg::REQ_BITS_DEF,
  parameter int QUEUE_DEPTH = mtpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mtpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mtpc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mtpc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  // Input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic [ADDR_BITS-1:0]             in_word_address,
  input  logic [63:0]                      in_read_data,
  input  logic [REQ_BITS-1:0]              in_requester_id,
  // Result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [63:0]                      out_expected_word,
  output logic                             out_mismatch,
  output logic                             out_failure_seen,
  output logic [ADDR_BITS-1:0]             out_first_fail_address,
  output logic [63:0]                      out_first_fail_expected,
  output logic [63:0]                      out_first_fail_actual,
  output logic [REQ_BITS-1:0]              out_first_fail_requester
);
  import mtpc_pkg::*;

  localparam int ITEM_W = 2 + ADDR_BITS + 64 + REQ_BITS + 64;

  logic [2:0]            pat_sel_r;
  logic [63:0]           seed_r;
  logic [31:0]           pass_round_r;
  cfg_t                  cfg;
  logic                  cfg_write;
  logic [1:0]            reg_idx;

  logic                  fq_valid, fq_ready;
  act_t                  fq_act;
  logic [ADDR_BITS-1:0]  fq_addr;
  logic [63:0]           fq_rd;
  logic [REQ_BITS-1:0]   fq_req;
  logic [63:0]           fq_word;
  logic [ITEM_W-1:0]     fq_data;

  logic                  bq_valid, bq_ready;
  logic [ITEM_W-1:0]     bq_data;
  act_t                  bq_act;
  logic [ADDR_BITS-1:0]  bq_addr;
  logic [63:0]           bq_rd;
  logic [REQ_BITS-1:0]   bq_req;
  logic [63:0]           bq_word;

  // Register file access: pready is always high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_sel_r    <= '0;
      seed_r       <= '0;
      pass_round_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_PATTERN: pat_sel_r    <= pwdata[2:0];
        REG_SEED:    seed_r       <= pwdata;
        REG_ROUND:   pass_round_r <= pwdata[31:0];
        default:     pat_sel_r    <= pat_sel_r;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_PATTERN: prdata = CFG_DATA_W'(pat_sel_r);
      REG_SEED:    prdata = seed_r;
      REG_ROUND:   prdata = CFG_DATA_W'(pass_round_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.pat_sel    = pat_sel_r;
  assign cfg.seed       = seed_r;
  assign cfg.pass_round = pass_round_r;

  // Front end: accept, classify and form the expected word.
  mtpc_front #(
    .ADDR_BITS (ADDR_BITS),
    .REQ_BITS  (REQ_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_word_address (in_word_address),
    .in_read_data    (in_read_data),
    .in_requester_id (in_requester_id),
    .q_valid         (fq_valid),
    .q_ready         (fq_ready),
    .q_act           (fq_act),
    .q_addr          (fq_addr),
    .q_rd            (fq_rd),
    .q_req           (fq_req),
    .q_word          (fq_word)
  );

  // Item queue between front and back.
  assign fq_data = {fq_act, fq_addr, fq_rd, fq_req, fq_word};

  mtpc_fifo #(
    .W     (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  assign bq_act  = act_t'(bq_data[ITEM_W-1 -: 2]);
  assign bq_addr = bq_data[ITEM_W-3 -: ADDR_BITS];
  assign bq_rd   = bq_data[REQ_BITS+64 +: 64];
  assign bq_req  = bq_data[64 +: REQ_BITS];
  assign bq_word = bq_data[63:0];

  // Back end: compare, failure record and result register.
  mtpc_back #(
    .ADDR_BITS (ADDR_BITS),
    .REQ_BITS  (REQ_BITS)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_valid                  (bq_valid),
    .q_ready                  (bq_ready),
    .q_act                    (bq_act),
    .q_addr                   (bq_addr),
    .q_rd                     (bq_rd),
    .q_req                    (bq_req),
    .q_word                   (bq_word),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_expected_word        (out_expected_word),
    .out_mismatch             (out_mismatch),
    .out_failure_seen         (out_failure_seen),
    .out_first_fail_address   (out_first_fail_address),
    .out_first_fail_expected  (out_first_fail_expected),
    .out_first_fail_actual    (out_first_fail_actual),
    .out_first_fail_requester (out_first_fail_requester)
  );

endmodule
